@@ hdl/rtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

    // Parse phases of one string.
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_ZERO_X = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // Digit value returned for a byte that is no digit in any base.
    localparam logic [5:0] DIG_NONE = 6'd36;

    // Bases with a meaning of their own.
    localparam logic [5:0] RADIX_AUTO = 6'd0;
    localparam logic [5:0] RADIX_BAD  = 6'd1;
    localparam logic [5:0] RADIX_OCT  = 6'd8;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_HEX  = 6'd16;
    localparam logic [5:0] RADIX_MAX  = 6'd36;

    // Characters the parser looks for.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Configuration register indexes.
    localparam logic REG_RADIX  = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [5:0] RADIX_RESET  = 6'd10;
    localparam logic       SIGNED_RESET = 1'b1;

    // Saturation limits.
    localparam logic [63:0] LIM_POS      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_NEG      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIM_UNSIGNED = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [5:0] radix_setting;
        logic       signed_mode;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] acc;
        logic        neg;
        logic [5:0]  radix;
        logic        seen;
        logic        sat;
    } t_parse_state;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic        parse_ok;
        logic [12:0] chars_consumed;
        logic        overflowed;
    } t_result;

    // Value of a digit character in bases up to 36.
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
            return v[5:0];
        end
        if (c >= CH_A_LO && c <= CH_Z_LO) begin
            v = c - CH_A_LO + 8'd10;
            return v[5:0];
        end
        if (c >= CH_A_UP && c <= CH_Z_UP) begin
            v = c - CH_A_UP + 8'd10;
            return v[5:0];
        end
        return DIG_NONE;
    endfunction

    // Space, tab, LF, VT, FF and CR (tab through CR are contiguous).
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

@@ hdl/rtp_ifaces.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One text character per transfer.
interface rtp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink (input valid, input text_char, input last_char, output ready);
endinterface

// One parse result per transfer.
interface rtp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] parsed_value;
    logic        parse_ok;
    logic [12:0] chars_consumed;
    logic        overflowed;

    modport source (output valid, output parsed_value, output parse_ok,
                    output chars_consumed, output overflowed, input ready);
    modport sink (input valid, input parsed_value, input parse_ok,
                  input chars_consumed, input overflowed, output ready);
endinterface

`default_nettype wire

@@ hdl/rtp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtp_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rtp_pkg::t_cfg      o_cfg
);
    import rtp_pkg::*;

    logic [5:0] r_radix;
    logic       r_signed;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RESET;
            r_signed <= SIGNED_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_RADIX:  r_radix  <= pwdata[5:0];
                REG_SIGNED: r_signed <= pwdata[0];
                default:    r_radix  <= r_radix;
            endcase
        end
    end

    // Read back the addressed register.
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_RADIX:  prdata = {26'd0, r_radix};
            REG_SIGNED: prdata = {31'd0, r_signed};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.radix_setting = r_radix;
    assign o_cfg.signed_mode   = r_signed;

endmodule

`default_nettype wire

@@ hdl/rtp_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtp_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rtp_char_if.sink   i_char,
    input  wire logic  i_advance,
    output logic       o_valid,
    output logic [7:0] o_text_char,
    output logic       o_last_char
);
    logic       r_valid;
    logic [7:0] r_text_char;
    logic       r_last_char;
    logic       load;

    // The register frees up whenever its item moves on to the parse step.
    assign i_char.ready = !r_valid || i_advance;
    assign load         = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_text_char <= i_char.text_char;
            r_last_char <= i_char.last_char;
        end
    end

    assign o_valid     = r_valid;
    assign o_text_char = r_text_char;
    assign o_last_char = r_last_char;

endmodule

`default_nettype wire

@@ hdl/rtp_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtp_step #(
    parameter int MAX_LEN = 4096,
    localparam int POS_W = $clog2(MAX_LEN + 1)
) (
    input  wire rtp_pkg::t_cfg        i_cfg,
    input  wire rtp_pkg::t_parse_state i_state,
    input  wire logic [POS_W-1:0] i_pos,
    input  wire logic [POS_W-1:0] i_end,
    input  wire logic [7:0]       i_text_char,
    input  wire logic             i_last_char,
    output rtp_pkg::t_parse_state o_state,
    output logic [POS_W-1:0]      o_pos,
    output logic [POS_W-1:0]      o_end,
    output rtp_pkg::t_result      o_result
);
    import rtp_pkg::*;

    localparam int EXT_W = POS_W + 13;

    t_parse_state nxt;
    logic [POS_W-1:0] nxt_end;
    logic [POS_W-1:0] pos_inc;
    logic [5:0]  dig;
    logic [5:0]  rad;
    logic        active;
    logic        body;
    logic        take;
    logic [63:0] limit;
    logic [69:0] prod;
    logic [EXT_W-1:0] end_ext;

    assign active  = i_pos < POS_W'(MAX_LEN);
    assign pos_inc = i_pos + POS_W'(1);
    assign dig     = digit_of(i_text_char);

    // One character of the parse: phase decision, then at most one digit
    // folded into the magnitude by a single multiply-add with a limit check.
    always_comb begin
        nxt     = i_state;
        nxt_end = i_end;
        rad     = i_state.radix;
        body    = 1'b0;
        take    = 1'b0;
        limit   = LIM_UNSIGNED;
        prod    = 70'd0;

        if (active) begin
            unique case (i_state.phase)
                PH_SPACE: begin
                    if (is_blank(i_text_char)) begin
                        nxt.phase = PH_SPACE;
                    end else if (i_text_char == CH_PLUS || i_text_char == CH_MINUS) begin
                        nxt.neg   = (i_text_char == CH_MINUS);
                        nxt.phase = PH_SIGNED;
                    end else begin
                        body = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    body = 1'b1;
                end
                PH_ZERO: begin
                    if (i_text_char == CH_X_LO || i_text_char == CH_X_UP) begin
                        nxt.phase = PH_ZERO_X;
                    end else begin
                        rad       = (i_state.radix == RADIX_AUTO) ? RADIX_OCT : i_state.radix;
                        nxt.radix = rad;
                        take      = dig < rad;
                        nxt.phase = take ? PH_DIGITS : PH_DONE;
                    end
                end
                PH_ZERO_X: begin
                    take = dig < RADIX_HEX;
                    if (take) begin
                        rad       = RADIX_HEX;
                        nxt.radix = RADIX_HEX;
                    end
                    nxt.phase = take ? PH_DIGITS : PH_DONE;
                end
                PH_DIGITS: begin
                    take      = dig < rad;
                    nxt.phase = take ? PH_DIGITS : PH_DONE;
                end
                default: begin
                    nxt.phase = i_state.phase;
                end
            endcase

            // First character of the number body, after blanks and sign.
            if (body) begin
                if (i_cfg.radix_setting == RADIX_BAD || i_cfg.radix_setting > RADIX_MAX) begin
                    nxt.phase = PH_DONE;
                end else if (i_text_char == CH_ZERO &&
                             (i_cfg.radix_setting == RADIX_AUTO ||
                              i_cfg.radix_setting == RADIX_HEX)) begin
                    nxt.radix = i_cfg.radix_setting;
                    nxt.seen  = 1'b1;
                    nxt_end   = pos_inc;
                    nxt.acc   = 64'd0;
                    nxt.phase = PH_ZERO;
                end else begin
                    rad = (i_cfg.radix_setting == RADIX_AUTO) ? RADIX_DEC
                                                              : i_cfg.radix_setting;
                    nxt.radix = rad;
                    take      = dig < rad;
                    nxt.phase = take ? PH_DIGITS : PH_DONE;
                end
            end

            // Accumulate one digit, saturating at the limit of the mode.
            if (take) begin
                nxt.seen = 1'b1;
                nxt_end  = pos_inc;
                if (i_cfg.signed_mode) begin
                    limit = nxt.neg ? LIM_NEG : LIM_POS;
                end
                prod = 70'(i_state.acc) * 70'(rad) + 70'(dig);
                if (!i_state.sat && rad >= 6'd2) begin
                    if (prod > 70'(limit)) begin
                        nxt.sat = 1'b1;
                        nxt.acc = limit;
                    end else begin
                        nxt.acc = prod[63:0];
                    end
                end
            end
        end
    end

    assign end_ext = EXT_W'(nxt_end);

    // Result of the string, and a fresh state after its last character.
    always_comb begin
        o_result = '0;
        if (nxt.seen) begin
            o_result.parsed_value   = nxt.neg ? (~nxt.acc + 64'd1) : nxt.acc;
            o_result.parse_ok       = 1'b1;
            o_result.chars_consumed = end_ext[12:0];
            o_result.overflowed     = nxt.sat;
        end

        if (i_last_char) begin
            o_state       = '0;
            o_state.phase = PH_SPACE;
            o_pos         = '0;
            o_end         = '0;
        end else begin
            o_state = nxt;
            o_pos   = active ? pos_inc : i_pos;
            o_end   = nxt_end;
        end
    end

endmodule

`default_nettype wire

@@ hdl/radix_integer_text_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Transfer     Payload
// i_char    in    valid&ready  text_char[7:0], last_char
// o_result  out   valid&ready  parsed_value[63:0], parse_ok, chars_consumed[12:0], overflowed
// APB       in    psel&penable&pwrite  reg 0 radix_setting @0x0, reg 1 signed_mode @0x4
//
// One character is taken every cycle unless a character marked last stalls on a
// full result register; a result becomes valid once the last character has passed
// through the input register and then the parse step with its multiply-add, which
// writes the state and result registers.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A full result register stalls only a character marked last; other
// characters keep flowing while the result waits.

module radix_integer_text_parser_core #(
    parameter int MAX_LEN = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rtp_char_if.sink         i_char,
    rtp_result_if.source     o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rtp_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    t_cfg         cfg;
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      r_out;
    t_result      n_out;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] r_end;
    logic [POS_W-1:0] n_end;
    logic         r_out_valid;
    logic         in_valid;
    logic [7:0]   in_text_char;
    logic         in_last_char;
    logic         advance;

    rtp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rtp_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .i_advance   (advance),
        .o_valid     (in_valid),
        .o_text_char (in_text_char),
        .o_last_char (in_last_char)
    );

    rtp_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_pos       (r_pos),
        .i_end       (r_end),
        .i_text_char (in_text_char),
        .i_last_char (in_last_char),
        .o_state     (n_state),
        .o_pos       (n_pos),
        .o_end       (n_end),
        .o_result    (n_out)
    );

    // A character moves on unless it closes a string and the result slot is taken.
    assign advance = in_valid && (!in_last_char || !r_out_valid || o_result.ready);

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_SPACE, default: '0};
            r_pos   <= '0;
            r_end   <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_end   <= n_end;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && in_last_char) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && in_last_char) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.parsed_value   = r_out.parsed_value;
    assign o_result.parse_ok       = r_out.parse_ok;
    assign o_result.chars_consumed = r_out.chars_consumed;
    assign o_result.overflowed     = r_out.overflowed;

    // A new result appears only after a closing character was parsed.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && in_last_char))
        else $error("result raised without a closing character");

    // A closing character always leaves a fresh parse state behind.
    a_fresh_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && in_last_char) |=> (r_state.phase == PH_SPACE && r_pos == '0
                                       && r_end == '0 && !r_state.seen))
        else $error("parse state not cleared after end of string");

    // A failed parse reports all-zero fields.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.parse_ok) |-> (r_out.parsed_value == 64'd0
                                              && r_out.chars_consumed == 13'd0
                                              && !r_out.overflowed))
        else $error("failed parse with nonzero result fields");

    // A saturated digit string must also have consumed characters.
    a_sat_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sat) |-> (r_state.seen && r_end != '0))
        else $error("saturation without a digit");

endmodule

`default_nettype wire
